FILE: hw/rtl/dntl_pkg.sv
// dntl_pkg: constants and character helpers for the device name text lookup.
// Used by device_name_text_lookup_unit; no dependencies.
`timescale 1ns / 1ps

package dntl_pkg;

  // Name buffer size; at most NAME_CAPACITY-1 characters are emitted.
  localparam int NAME_CAPACITY = 64;
  localparam int CNT_W         = $clog2(NAME_CAPACITY);

  // Configuration register indexes.
  localparam logic REG_VENDOR_ID = 1'b0;
  localparam logic REG_DEVICE_ID = 1'b1;

  localparam logic [7:0] CHAR_NL  = 8'h0a;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // Lowercase hex character of digit idx (0 = most significant) of id.
  function automatic logic [7:0] hex_char(input logic [15:0] id, input logic [1:0] idx);
    logic [3:0] nib;
    begin
      unique case (idx)
        2'd0: nib = id[15:12];
        2'd1: nib = id[11:8];
        2'd2: nib = id[7:4];
        default: nib = id[3:0];
      endcase
      if (nib < 4'd10) begin
        hex_char = 8'h30 + {4'h0, nib};
      end else begin
        hex_char = 8'h57 + {4'h0, nib};
      end
    end
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Hex digit of either case; marks the start of the next vendor block.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage

FILE: hw/rtl/device_name_text_lookup_unit.sv
// Device name lookup over a streamed ID-database text file.
// Output: a not-found item is presented the cycle after the deciding byte; the first
// name character is shown once the line end has started emission and it has been
// read from the name store; the rest follow one per cycle while m_tready stays high.
// Throughput: one text byte per cycle; input stalls while the name store is read
// out (one read port), and while an output item is untaken.
// Reset: synchronous; lookup state and counters clear, the name store is not cleared.
// Depends on dntl_pkg.
`timescale 1ns / 1ps

module device_name_text_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // text input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] first_of_file
  input  logic        s_tlast,   // end_of_file
  // name output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] name_char
  output logic        m_tuser,   // [0] name_found
  output logic        m_tlast    // name_last
);

  localparam int CW = dntl_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(dntl_pkg::NAME_CAPACITY - 1);

  localparam logic [2:0] PH_SEEK        = 3'd0;
  localparam logic [2:0] PH_SKIP_VENDOR = 3'd1;
  localparam logic [2:0] PH_LINE        = 3'd2;
  localparam logic [2:0] PH_SKIP_LINE   = 3'd3;
  localparam logic [2:0] PH_COLLECT     = 3'd4;
  localparam logic [2:0] PH_DONE        = 3'd5;
  localparam logic [2:0] PH_EMIT        = 3'd6;

  logic [15:0]   vendor_id;
  logic [15:0]   device_id;
  logic [2:0]    phase;
  logic [2:0]    match_pos;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] trimmed_count;
  logic [CW-1:0] emit_pos;

  logic [7:0]    name_store [0:dntl_pkg::NAME_CAPACITY-1];
  logic [7:0]    rd_char;
  logic          out_valid;
  logic          out_found;
  logic          out_last;

  logic [2:0]    ph;
  logic [2:0]    mp;
  logic [CW-1:0] st;
  logic [CW-1:0] tr;
  logic [2:0]    phase_next;
  logic [2:0]    match_pos_next;
  logic [CW-1:0] stored_count_next;
  logic [CW-1:0] trimmed_count_next;
  logic          store_we;
  logic          not_found;
  logic          name_end;
  logic          start_emit;
  logic          s_accept;
  logic          emit_go;
  logic          emit_final;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_id <= '0;
      device_id <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dntl_pkg::REG_VENDOR_ID: vendor_id <= cfg_data;
        dntl_pkg::REG_DEVICE_ID: device_id <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready   = (phase != PH_EMIT) && (!out_valid || m_tready);
  assign s_accept   = s_tvalid && s_tready;
  assign emit_go    = (phase == PH_EMIT) && (!out_valid || m_tready);
  assign emit_final = ({1'b0, emit_pos} + 1'b1) == {1'b0, trimmed_count};

  always_comb begin
    ph = s_tuser ? PH_SEEK : phase;
    mp = s_tuser ? 3'd0 : match_pos;
    st = s_tuser ? '0 : stored_count;
    tr = s_tuser ? '0 : trimmed_count;
    phase_next         = ph;
    match_pos_next     = mp;
    stored_count_next  = st;
    trimmed_count_next = tr;
    store_we   = 1'b0;
    not_found  = 1'b0;
    name_end   = 1'b0;
    start_emit = 1'b0;

    unique case (ph)
      PH_SEEK: begin
        if (s_tdata == dntl_pkg::CHAR_NL) begin
          match_pos_next = 3'd1;
        end else if (mp >= 3'd1 && mp <= 3'd4 &&
                     s_tdata == dntl_pkg::hex_char(vendor_id, 2'(mp - 3'd1))) begin
          if (mp == 3'd4) begin
            phase_next     = PH_SKIP_VENDOR;
            match_pos_next = 3'd0;
          end else begin
            match_pos_next = mp + 3'd1;
          end
        end else begin
          match_pos_next = 3'd0;
        end
      end
      PH_SKIP_VENDOR, PH_SKIP_LINE: begin
        if (s_tdata == dntl_pkg::CHAR_NL) begin
          phase_next     = PH_LINE;
          match_pos_next = 3'd1;
        end
      end
      PH_LINE: begin
        if (mp <= 3'd1) begin
          priority if (s_tdata == dntl_pkg::CHAR_TAB) begin
            match_pos_next = 3'd2;
          end else if (s_tdata == dntl_pkg::CHAR_NL) begin
            match_pos_next = 3'd1;
          end else if (dntl_pkg::is_hex(s_tdata)) begin
            // next vendor block reached
            not_found = 1'b1;
          end else begin
            phase_next = PH_SKIP_LINE;
          end
        end else if (s_tdata == dntl_pkg::hex_char(device_id, 2'(mp - 3'd2))) begin
          if (mp >= 3'd5) begin
            phase_next         = PH_COLLECT;
            stored_count_next  = '0;
            trimmed_count_next = '0;
            match_pos_next     = 3'd0;
          end else begin
            match_pos_next = mp + 3'd1;
          end
        end else if (s_tdata == dntl_pkg::CHAR_NL) begin
          match_pos_next = 3'd1;
        end else begin
          phase_next = PH_SKIP_LINE;
        end
      end
      PH_COLLECT: begin
        if (s_tdata == dntl_pkg::CHAR_NL) begin
          name_end       = 1'b1;
          match_pos_next = 3'd0;
        end else if (!(st == '0 && dntl_pkg::is_space(s_tdata))) begin
          // counts saturate at the buffer limit; only the kept prefix matters
          if (st != MAX_CNT) begin
            store_we          = 1'b1;
            stored_count_next = st + 1'b1;
          end
          if (!dntl_pkg::is_space(s_tdata)) begin
            trimmed_count_next = stored_count_next;
          end
        end
      end
      default: phase_next = PH_DONE;
    endcase

    if (s_tlast && !not_found && !name_end && phase_next != PH_DONE) begin
      if (phase_next == PH_COLLECT) begin
        name_end = 1'b1;
      end else begin
        not_found = 1'b1;
      end
    end
    if (name_end) begin
      if (trimmed_count_next == '0) begin
        not_found = 1'b1;
      end else begin
        start_emit = 1'b1;
      end
    end
    if (not_found) begin
      phase_next = PH_DONE;
    end else if (start_emit) begin
      phase_next = PH_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK;
      match_pos     <= 3'd0;
      stored_count  <= '0;
      trimmed_count <= '0;
      emit_pos      <= '0;
    end else if (s_accept) begin
      phase         <= phase_next;
      match_pos     <= match_pos_next;
      stored_count  <= stored_count_next;
      trimmed_count <= trimmed_count_next;
      emit_pos      <= '0;
    end else if (emit_go) begin
      emit_pos <= emit_pos + 1'b1;
      if (emit_final) begin
        phase <= PH_DONE;
      end
    end
  end

  // Writes happen only while collecting and reads only while emitting with the
  // input stalled, so the two ports never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (s_accept && store_we) begin
      name_store[st] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      rd_char <= name_store[emit_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_found <= 1'b0;
      out_last  <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
      out_found <= 1'b1;
      out_last  <= emit_final;
    end else if (s_accept && not_found) begin
      out_valid <= 1'b1;
      out_found <= 1'b0;
      out_last  <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_found ? rd_char : 8'h00;
  assign m_tuser  = out_found;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_trim_within_stored: assert property (@(posedge clk) disable iff (rst)
    trimmed_count <= stored_count)
    else $error("trimmed count exceeds stored count");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT) |-> (emit_pos < trimmed_count))
    else $error("emit position beyond name length");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (phase != PH_EMIT))
    else $error("final item shown while still emitting");

  a_name_follows_emit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && !$past(m_tvalid)) |-> ($past(phase) == PH_EMIT))
    else $error("name character without emission");
`endif

endmodule
